@@ sv/dbpid_pkg.sv @@
// Shared types, constants and register codes of the dual-beam pass and impact detector.
package dbpid_pkg;

   localparam int TIME_BITS_DEF = 32;
   localparam int AXIS_BITS_DEF = 16;

   localparam int DIST_W    = 13;
   localparam int LEVEL_W   = 12;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;

   localparam int FIFO_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_DISTANCE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_WINDOW       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIBRATION_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VIBRATION_HOLDOFF = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_LIMIT       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_LIMIT        = 3'd5;

   localparam logic [12:0] NEAR_DISTANCE_RST     = 13'd150;
   localparam logic [15:0] PASS_WINDOW_RST       = 16'd500;
   localparam logic [11:0] VIBRATION_LIMIT_RST   = 12'd2000;
   localparam logic [15:0] VIBRATION_HOLDOFF_RST = 16'd200;
   localparam logic [15:0] ACCEL_LIMIT_RST       = 16'd5120;
   localparam logic [15:0] GYRO_LIMIT_RST        = 16'd512;

   // level/4095 > 0.3 and level/4095 < 0.2, as integer bounds
   localparam logic [LEVEL_W-1:0] SHOT_LEVEL_MIN = 12'd1228;
   localparam logic [LEVEL_W-1:0] CALM_LEVEL_MAX = 12'd819;

   // accel / (spin + 0.1 rad/s) > 3  <=>  5*accel > 15*spin + 384
   localparam int STRIKE_ACC_K  = 5;
   localparam int STRIKE_SPIN_K = 15;
   localparam int STRIKE_OFFSET = 384;

   typedef struct packed {
      logic [12:0] near_distance;
      logic [15:0] pass_window;
      logic [11:0] vibration_limit;
      logic [15:0] vibration_holdoff;
      logic [15:0] accel_limit;
      logic [15:0] gyro_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SQUARE,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_ROOT,
      B_COMMIT
   } back_state_type;

endpackage

@@ sv/dual_beam_pass_impact_detector_unit.sv @@
// Top level of the dual-beam pass and impact detector: register file and front/back ends.
//
// One request transaction is one polling step and gives one response transaction holding
// the latches and arm flags after the step. The front end takes a transaction through
// capture, three square-and-add steps and a queue write; the back end takes it through a
// queue read, the two bit-serial square roots and a commit, so the sustained rate is set
// by the square-root units. A two-entry queue sits between the ends and the response
// register lets a new transaction enter while a result is stalled.
module dual_beam_pass_impact_detector_unit #(
   parameter int TIME_BITS = dbpid_pkg::TIME_BITS_DEF,
   parameter int AXIS_BITS = dbpid_pkg::AXIS_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [dbpid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dbpid_pkg::CSR_W-1:0]          csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [TIME_BITS-1:0]                 req_now_ms,
   input  logic [dbpid_pkg::DIST_W-1:0]         req_upper_distance,
   input  logic [dbpid_pkg::DIST_W-1:0]         req_lower_distance,
   input  logic [dbpid_pkg::LEVEL_W-1:0]        req_shake_level,
   input  logic signed [AXIS_BITS-1:0]          req_accel_x,
   input  logic signed [AXIS_BITS-1:0]          req_accel_y,
   input  logic signed [AXIS_BITS-1:0]          req_accel_z,
   input  logic signed [AXIS_BITS-1:0]          req_spin_x,
   input  logic signed [AXIS_BITS-1:0]          req_spin_y,
   input  logic signed [AXIS_BITS-1:0]          req_spin_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_pass_detected,
   output logic                                 rsp_shot_detected,
   output logic                                 rsp_collision_detected,
   output logic                                 rsp_upper_armed,
   output logic                                 rsp_lower_armed,
   output logic [dbpid_pkg::LEVEL_W-1:0]        rsp_level_seen
);

   localparam int ENTRY_W = 1 + TIME_BITS + 2 * dbpid_pkg::DIST_W + dbpid_pkg::LEVEL_W
                            + 4 * AXIS_BITS;

   dbpid_pkg::cfg_type cfg_ff, cfg_in;

   logic               push, full, pop, pop_valid;
   logic [ENTRY_W-1:0] push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            dbpid_pkg::CSR_NEAR_DISTANCE:     cfg_in.near_distance     = csr_wdata[12:0];
            dbpid_pkg::CSR_PASS_WINDOW:       cfg_in.pass_window       = csr_wdata;
            dbpid_pkg::CSR_VIBRATION_LIMIT:   cfg_in.vibration_limit   = csr_wdata[11:0];
            dbpid_pkg::CSR_VIBRATION_HOLDOFF: cfg_in.vibration_holdoff = csr_wdata;
            dbpid_pkg::CSR_ACCEL_LIMIT:       cfg_in.accel_limit       = csr_wdata;
            dbpid_pkg::CSR_GYRO_LIMIT:        cfg_in.gyro_limit        = csr_wdata;
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_distance     <= dbpid_pkg::NEAR_DISTANCE_RST;
         cfg_ff.pass_window       <= dbpid_pkg::PASS_WINDOW_RST;
         cfg_ff.vibration_limit   <= dbpid_pkg::VIBRATION_LIMIT_RST;
         cfg_ff.vibration_holdoff <= dbpid_pkg::VIBRATION_HOLDOFF_RST;
         cfg_ff.accel_limit       <= dbpid_pkg::ACCEL_LIMIT_RST;
         cfg_ff.gyro_limit        <= dbpid_pkg::GYRO_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dbpid_front #(
      .TIME_BITS (TIME_BITS),
      .AXIS_BITS (AXIS_BITS),
      .ENTRY_W   (ENTRY_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_now_ms         (req_now_ms),
      .req_upper_distance (req_upper_distance),
      .req_lower_distance (req_lower_distance),
      .req_shake_level    (req_shake_level),
      .req_accel_x        (req_accel_x),
      .req_accel_y        (req_accel_y),
      .req_accel_z        (req_accel_z),
      .req_spin_x         (req_spin_x),
      .req_spin_y         (req_spin_y),
      .req_spin_z         (req_spin_z),
      .push               (push),
      .push_data          (push_data),
      .full               (full)
   );

   dbpid_fifo #(.DATA_W(ENTRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   dbpid_back #(
      .TIME_BITS (TIME_BITS),
      .AXIS_BITS (AXIS_BITS),
      .ENTRY_W   (ENTRY_W)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .pop_valid              (pop_valid),
      .pop                    (pop),
      .pop_data               (pop_data),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_pass_detected      (rsp_pass_detected),
      .rsp_shot_detected      (rsp_shot_detected),
      .rsp_collision_detected (rsp_collision_detected),
      .rsp_upper_armed        (rsp_upper_armed),
      .rsp_lower_armed        (rsp_lower_armed),
      .rsp_level_seen         (rsp_level_seen)
   );

endmodule

@@ sv/dbpid_sqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
module dbpid_sqrt #(
   parameter int ROOT_W = dbpid_pkg::AXIS_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic                  idle,
   output logic [ROOT_W-1:0]     root
);

   localparam int CW = $clog2(ROOT_W + 1);

   logic [2*ROOT_W-1:0] rad_ff, rad_in;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   logic [ROOT_W+1:0]   rem_sh;
   logic [ROOT_W+1:0]   trial;
   logic                fits;

   always_comb begin
      rem_sh  = {rem_ff[ROOT_W-1:0], rad_ff[2*ROOT_W-1:2*ROOT_W-2]};
      trial   = {root_ff, 2'b01};
      fits    = rem_sh >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(ROOT_W);
      end else if (cnt_ff != '0) begin
         rad_in  = rad_ff << 2;
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign idle = (cnt_ff == '0);
   assign root = root_ff;

endmodule

@@ sv/dbpid_fifo.sv @@
// Two-entry transaction queue between the front and back ends.
module dbpid_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PW = $clog2(dbpid_pkg::FIFO_DEPTH);
   localparam int NW = $clog2(dbpid_pkg::FIFO_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [dbpid_pkg::FIFO_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == NW'(dbpid_pkg::FIFO_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(dbpid_pkg::FIFO_DEPTH))
      else $error("queue count beyond depth");

endmodule

@@ sv/dbpid_front.sv @@
// Front end: accepts transactions and forms the squared motion magnitudes.
module dbpid_front #(
   parameter int TIME_BITS = dbpid_pkg::TIME_BITS_DEF,
   parameter int AXIS_BITS = dbpid_pkg::AXIS_BITS_DEF,
   parameter int ENTRY_W   = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [TIME_BITS-1:0]              req_now_ms,
   input  logic [dbpid_pkg::DIST_W-1:0]      req_upper_distance,
   input  logic [dbpid_pkg::DIST_W-1:0]      req_lower_distance,
   input  logic [dbpid_pkg::LEVEL_W-1:0]     req_shake_level,
   input  logic signed [AXIS_BITS-1:0]       req_accel_x,
   input  logic signed [AXIS_BITS-1:0]       req_accel_y,
   input  logic signed [AXIS_BITS-1:0]       req_accel_z,
   input  logic signed [AXIS_BITS-1:0]       req_spin_x,
   input  logic signed [AXIS_BITS-1:0]       req_spin_y,
   input  logic signed [AXIS_BITS-1:0]       req_spin_z,
   output logic                              push,
   output logic [ENTRY_W-1:0]                push_data,
   input  logic                              full
);

   localparam int SQ_W = 2 * AXIS_BITS;

   dbpid_pkg::front_state_type state_ff, state_in;

   logic                           mode_ff, mode_in;
   logic [TIME_BITS-1:0]           now_ff, now_in;
   logic [dbpid_pkg::DIST_W-1:0]   upper_ff, upper_in;
   logic [dbpid_pkg::DIST_W-1:0]   lower_ff, lower_in;
   logic [dbpid_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic [AXIS_BITS-1:0]           acc_abs_ff [3];
   logic [AXIS_BITS-1:0]           acc_abs_in [3];
   logic [AXIS_BITS-1:0]           spin_abs_ff [3];
   logic [AXIS_BITS-1:0]           spin_abs_in [3];
   logic [SQ_W-1:0]                acc_sum_ff, acc_sum_in;
   logic [SQ_W-1:0]                spin_sum_ff, spin_sum_in;
   logic [1:0]                     cnt_ff, cnt_in;

   logic signed [AXIS_BITS-1:0]    acc_raw [3];
   logic signed [AXIS_BITS-1:0]    spin_raw [3];
   logic                           accept;
   logic [SQ_W-1:0]                acc_sq;
   logic [SQ_W-1:0]                spin_sq;

   assign acc_raw[0]  = req_accel_x;
   assign acc_raw[1]  = req_accel_y;
   assign acc_raw[2]  = req_accel_z;
   assign spin_raw[0] = req_spin_x;
   assign spin_raw[1] = req_spin_y;
   assign spin_raw[2] = req_spin_z;

   assign accept  = req_valid && !req_stall;
   assign acc_sq  = SQ_W'(acc_abs_ff[0]) * SQ_W'(acc_abs_ff[0]);
   assign spin_sq = SQ_W'(spin_abs_ff[0]) * SQ_W'(spin_abs_ff[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbpid_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      push      = 1'b0;
      unique case (state_ff)
         dbpid_pkg::F_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = dbpid_pkg::F_SQUARE;
            end
         end
         dbpid_pkg::F_SQUARE: begin
            if (cnt_ff == 2'd2) begin
               state_in = dbpid_pkg::F_PUSH;
            end
         end
         dbpid_pkg::F_PUSH: begin
            push = !full;
            if (!full) begin
               state_in = dbpid_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = dbpid_pkg::F_IDLE;
         end
      endcase
   end

   always_comb begin
      mode_in     = mode_ff;
      now_in      = now_ff;
      upper_in    = upper_ff;
      lower_in    = lower_ff;
      level_in    = level_ff;
      acc_sum_in  = acc_sum_ff;
      spin_sum_in = spin_sum_ff;
      cnt_in      = cnt_ff;
      for (int i = 0; i < 3; i++) begin
         acc_abs_in[i]  = acc_abs_ff[i];
         spin_abs_in[i] = spin_abs_ff[i];
      end
      if (accept) begin
         mode_in     = req_mode;
         now_in      = req_now_ms;
         upper_in    = req_upper_distance;
         lower_in    = req_lower_distance;
         level_in    = req_shake_level;
         acc_sum_in  = '0;
         spin_sum_in = '0;
         cnt_in      = '0;
         for (int i = 0; i < 3; i++) begin
            acc_abs_in[i]  = acc_raw[i][AXIS_BITS-1] ? AXIS_BITS'(-acc_raw[i])
                                                     : AXIS_BITS'(acc_raw[i]);
            spin_abs_in[i] = spin_raw[i][AXIS_BITS-1] ? AXIS_BITS'(-spin_raw[i])
                                                      : AXIS_BITS'(spin_raw[i]);
         end
      end else if (state_ff == dbpid_pkg::F_SQUARE) begin
         acc_sum_in     = acc_sum_ff + acc_sq;
         spin_sum_in    = spin_sum_ff + spin_sq;
         cnt_in         = cnt_ff + 2'd1;
         acc_abs_in[0]  = acc_abs_ff[1];
         acc_abs_in[1]  = acc_abs_ff[2];
         spin_abs_in[0] = spin_abs_ff[1];
         spin_abs_in[1] = spin_abs_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      now_ff      <= now_in;
      upper_ff    <= upper_in;
      lower_ff    <= lower_in;
      level_ff    <= level_in;
      acc_sum_ff  <= acc_sum_in;
      spin_sum_ff <= spin_sum_in;
      cnt_ff      <= cnt_in;
      for (int i = 0; i < 3; i++) begin
         acc_abs_ff[i]  <= acc_abs_in[i];
         spin_abs_ff[i] <= spin_abs_in[i];
      end
   end

   assign push_data = {mode_ff, now_ff, upper_ff, lower_ff, level_ff,
                       acc_sum_ff, spin_sum_ff};

endmodule

@@ sv/dbpid_back.sv @@
// Back end: square roots, beam, vibration and impact state, and the result register.
module dbpid_back #(
   parameter int TIME_BITS = dbpid_pkg::TIME_BITS_DEF,
   parameter int AXIS_BITS = dbpid_pkg::AXIS_BITS_DEF,
   parameter int ENTRY_W   = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dbpid_pkg::cfg_type                cfg,
   input  logic                              pop_valid,
   output logic                              pop,
   input  logic [ENTRY_W-1:0]                pop_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_pass_detected,
   output logic                              rsp_shot_detected,
   output logic                              rsp_collision_detected,
   output logic                              rsp_upper_armed,
   output logic                              rsp_lower_armed,
   output logic [dbpid_pkg::LEVEL_W-1:0]     rsp_level_seen
);

   localparam int SQ_W = 2 * AXIS_BITS;
   localparam int MW   = AXIS_BITS + 18;

   dbpid_pkg::back_state_type state_ff, state_in;

   logic                           p_mode;
   logic [TIME_BITS-1:0]           p_now;
   logic [dbpid_pkg::DIST_W-1:0]   p_upper;
   logic [dbpid_pkg::DIST_W-1:0]   p_lower;
   logic [dbpid_pkg::LEVEL_W-1:0]  p_level;
   logic [SQ_W-1:0]                p_acc_sq;
   logic [SQ_W-1:0]                p_spin_sq;

   logic                           mode_ff;
   logic [TIME_BITS-1:0]           now_ff;
   logic [dbpid_pkg::DIST_W-1:0]   upper_ff;
   logic [dbpid_pkg::DIST_W-1:0]   lower_ff;
   logic [dbpid_pkg::LEVEL_W-1:0]  level_ff;

   logic                           upper_flag_ff, upper_flag_in;
   logic                           lower_flag_ff, lower_flag_in;
   logic [TIME_BITS-1:0]           upper_stamp_ff, upper_stamp_in;
   logic [TIME_BITS-1:0]           lower_stamp_ff, lower_stamp_in;
   logic [TIME_BITS-1:0]           shake_stamp_ff, shake_stamp_in;
   logic                           pass_ff, pass_in;
   logic                           shot_ff, shot_in;
   logic                           coll_ff, coll_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [dbpid_pkg::LEVEL_W-1:0]  level_seen_ff, level_seen_in;

   logic                           acc_idle, spin_idle;
   logic [AXIS_BITS-1:0]           acc_root, spin_root;
   logic                           commit;

   logic [TIME_BITS-1:0]           pw_t, hold_t;
   logic [TIME_BITS-1:0]           d_upper, d_lower, d_shake;
   logic                           up_near, lo_near, u_arm, l_arm, u_flag1, l_flag1;
   logic                           pass1;
   logic [MW-1:0]                  acc_w, spin_w, alim_w, glim_w;
   logic                           acc_over, trig, strike, wild;

   assign {p_mode, p_now, p_upper, p_lower, p_level, p_acc_sq, p_spin_sq} = pop_data;

   assign pop = (state_ff == dbpid_pkg::B_IDLE) && pop_valid;

   dbpid_sqrt #(.ROOT_W(AXIS_BITS)) u_acc_root (
      .clock    (clock),
      .reset    (reset),
      .start    (pop),
      .radicand (p_acc_sq),
      .idle     (acc_idle),
      .root     (acc_root)
   );

   dbpid_sqrt #(.ROOT_W(AXIS_BITS)) u_spin_root (
      .clock    (clock),
      .reset    (reset),
      .start    (pop),
      .radicand (p_spin_sq),
      .idle     (spin_idle),
      .root     (spin_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbpid_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      commit   = 1'b0;
      unique case (state_ff)
         dbpid_pkg::B_IDLE: begin
            if (pop_valid) begin
               state_in = dbpid_pkg::B_ROOT;
            end
         end
         dbpid_pkg::B_ROOT: begin
            if (acc_idle && spin_idle) begin
               state_in = dbpid_pkg::B_COMMIT;
            end
         end
         dbpid_pkg::B_COMMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               commit   = 1'b1;
               state_in = dbpid_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = dbpid_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mode_ff  <= p_mode;
         now_ff   <= p_now;
         upper_ff <= p_upper;
         lower_ff <= p_lower;
         level_ff <= p_level;
      end
   end

   always_comb begin
      pw_t    = TIME_BITS'(cfg.pass_window);
      hold_t  = TIME_BITS'(cfg.vibration_holdoff);
      up_near = (upper_ff != '0) && (upper_ff < cfg.near_distance);
      lo_near = (lower_ff != '0) && (lower_ff < cfg.near_distance);

      // upper beam first, then lower beam sees the updated upper state
      u_arm   = up_near && !upper_flag_ff;
      u_flag1 = upper_flag_ff || u_arm;
      d_upper = u_arm ? '0 : (now_ff - upper_stamp_ff);
      pass1   = pass_ff || (u_arm && lower_flag_ff && ((now_ff - lower_stamp_ff) < pw_t));
      l_arm   = lo_near && !lower_flag_ff;
      l_flag1 = lower_flag_ff || l_arm;
      d_lower = l_arm ? '0 : (now_ff - lower_stamp_ff);
      d_shake = now_ff - shake_stamp_ff;

      acc_w    = MW'(acc_root);
      spin_w   = MW'(spin_root);
      alim_w   = MW'(cfg.accel_limit);
      glim_w   = MW'(cfg.gyro_limit);
      acc_over = acc_w > alim_w;
      trig     = acc_over || (spin_w > glim_w);
      strike   = (acc_w * MW'(dbpid_pkg::STRIKE_ACC_K) >
                  spin_w * MW'(dbpid_pkg::STRIKE_SPIN_K) + MW'(dbpid_pkg::STRIKE_OFFSET))
                 && acc_over && (level_ff > dbpid_pkg::SHOT_LEVEL_MIN);
      wild     = (spin_w > (glim_w << 1)) || (level_ff < dbpid_pkg::CALM_LEVEL_MAX);

      upper_flag_in  = upper_flag_ff;
      lower_flag_in  = lower_flag_ff;
      upper_stamp_in = upper_stamp_ff;
      lower_stamp_in = lower_stamp_ff;
      shake_stamp_in = shake_stamp_ff;
      pass_in        = pass_ff;
      shot_in        = shot_ff;
      coll_in        = coll_ff;
      level_seen_in  = level_seen_ff;

      if (commit) begin
         if (mode_ff) begin
            upper_flag_in  = 1'b0;
            lower_flag_in  = 1'b0;
            upper_stamp_in = '0;
            lower_stamp_in = '0;
            pass_in        = 1'b0;
            shot_in        = 1'b0;
            coll_in        = 1'b0;
            level_seen_in  = '0;
         end else begin
            upper_stamp_in = u_arm ? now_ff : upper_stamp_ff;
            lower_stamp_in = l_arm ? now_ff : lower_stamp_ff;
            pass_in        = pass1 || (l_arm && u_flag1 && (d_upper < pw_t));
            level_seen_in  = level_ff;
            if ((level_ff > cfg.vibration_limit) && (d_shake > hold_t)) begin
               shake_stamp_in = now_ff;
               if (!u_flag1 && !l_flag1) begin
                  coll_in = 1'b1;
               end
            end
            if (trig) begin
               if (strike) begin
                  shot_in = 1'b1;
               end else if (wild) begin
                  coll_in = 1'b1;
               end
            end
            upper_flag_in = u_flag1 && !(d_upper > pw_t);
            lower_flag_in = l_flag1 && !(d_lower > pw_t);
         end
      end

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_flag_ff  <= 1'b0;
         lower_flag_ff  <= 1'b0;
         upper_stamp_ff <= '0;
         lower_stamp_ff <= '0;
         shake_stamp_ff <= '0;
         pass_ff        <= 1'b0;
         shot_ff        <= 1'b0;
         coll_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         upper_flag_ff  <= upper_flag_in;
         lower_flag_ff  <= lower_flag_in;
         upper_stamp_ff <= upper_stamp_in;
         lower_stamp_ff <= lower_stamp_in;
         shake_stamp_ff <= shake_stamp_in;
         pass_ff        <= pass_in;
         shot_ff        <= shot_in;
         coll_ff        <= coll_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_seen_ff <= level_seen_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_pass_detected      = pass_ff;
   assign rsp_shot_detected      = shot_ff;
   assign rsp_collision_detected = coll_ff;
   assign rsp_upper_armed        = upper_flag_ff;
   assign rsp_lower_armed        = lower_flag_ff;
   assign rsp_level_seen         = level_seen_ff;

   a_roots_in_step : assert property (@(posedge clock) disable iff (reset)
      acc_idle == spin_idle)
      else $error("square root units out of step");

   a_commit_waits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == dbpid_pkg::B_COMMIT && rsp_valid_ff && rsp_stall)
      |=> (state_ff == dbpid_pkg::B_COMMIT))
      else $error("result overwritten while stalled");

   a_clear_result : assert property (@(posedge clock) disable iff (reset)
      (commit && mode_ff) |=> (!pass_ff && !shot_ff && !coll_ff && !upper_flag_ff &&
                               !lower_flag_ff && level_seen_ff == '0))
      else $error("clear transaction left state set");

endmodule
